// ----- rtl/gmsu_pkg.sv -----
// shared types and constants for the gap material stress update block
// no dependencies; imported by the trial datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package gmsu_pkg;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] strain_value;
    } cmd_t;

    typedef struct packed {
        logic [30:0] stress_out;
        logic [30:0] stiffness_out;
    } res_t;

    // one material point state set, used for both trial and committed copies
    typedef struct packed {
        logic signed [31:0] strain;
        logic [30:0]        stress;
        logic [30:0]        stiffness;
        logic signed [1:0]  direction;
        logic signed [31:0] reversal;
    } mat_state_t;

    typedef struct packed {
        logic [30:0]        modulus;
        logic [30:0]        yield_lim;
        logic signed [31:0] gap;
    } mat_cfg_t;

    localparam logic [2:0] OP_TOTAL  = 3'd0;
    localparam logic [2:0] OP_INCR   = 3'd1;
    localparam logic [2:0] OP_COMMIT = 3'd2;
    localparam logic [2:0] OP_REVERT = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_YIELD   = 2'd1;
    localparam logic [1:0] REG_GAP     = 2'd2;

    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_POS  = 2'sb01;
    localparam logic signed [1:0] DIR_NEG  = 2'sb11;

    localparam logic [30:0] MODULUS_RESET = 31'd65536;
    localparam logic [30:0] YIELD_RESET   = 31'd65536;

endpackage

`default_nettype wire

// ----- rtl/gmsu_trial.sv -----
// trial stress update: increment, gap and reversal handling, scaled product, clamp
// combinational; depends on gmsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmsu_trial (
    input  wire logic signed [31:0]   strain,
    input  wire gmsu_pkg::mat_state_t committed,
    input  wire gmsu_pkg::mat_state_t trial,
    input  wire gmsu_pkg::mat_cfg_t   cfg,
    output gmsu_pkg::mat_state_t      trial_new
);
    import gmsu_pkg::*;

    logic signed [32:0] incre_raw;
    logic               zero_incre;
    logic               dir_pos;
    logic               stress_zero;
    logic               reload;
    logic               reverse;
    logic               use_gap;
    logic signed [31:0] rev_new;
    logic signed [33:0] incre_gap;
    logic signed [33:0] incre_sel;
    logic               neg;
    logic [33:0]        mag;
    logic [40:0]        prod_hi;
    logic [54:0]        prod_lo;
    logic [42:0]        prod;
    logic signed [43:0] prod_signed;
    logic signed [43:0] sum;

    assign incre_raw   = $signed({strain[31], strain})
                       - $signed({committed.strain[31], committed.strain});
    assign zero_incre  = (incre_raw == '0);
    assign dir_pos     = !incre_raw[32];
    assign stress_zero = (committed.stress == '0);

    // reloading in tension from zero stress, or turning back from compression
    assign reload  = (committed.direction == DIR_POS) && dir_pos && stress_zero;
    assign reverse = (committed.direction == DIR_NEG) && dir_pos;
    assign use_gap = reload || (reverse && stress_zero);
    assign rev_new = reverse ? committed.strain : committed.reversal;

    assign incre_gap = $signed({{2{strain[31]}}, strain})
                     - $signed({{2{cfg.gap[31]}}, cfg.gap})
                     - $signed({{2{rev_new[31]}}, rev_new});

    always_comb
    begin
        if (use_gap)
        begin
            incre_sel = incre_gap[33] ? '0 : incre_gap;
        end
        else
        begin
            incre_sel = $signed({incre_raw[32], incre_raw});
        end
    end

    assign neg = incre_sel[33];
    assign mag = neg ? 34'(-incre_sel) : 34'(incre_sel);

    // modulus * |incre| >> 24, split so each partial product stays narrow
    assign prod_hi = 41'(cfg.modulus) * 41'(mag[33:24]);
    assign prod_lo = 55'(cfg.modulus) * 55'(mag[23:0]);
    assign prod    = 43'(prod_hi) + 43'(prod_lo[54:24]);

    assign prod_signed = neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    assign sum         = $signed({13'b0, committed.stress}) + prod_signed;

    always_comb
    begin
        trial_new        = trial;
        trial_new.strain = strain;
        if (!zero_incre)
        begin
            trial_new.reversal  = rev_new;
            trial_new.direction = dir_pos ? DIR_POS : DIR_NEG;
            if (sum[43])
            begin
                trial_new.stress    = '0;
                trial_new.stiffness = '0;
            end
            else if (sum[42:0] > {12'b0, cfg.yield_lim})
            begin
                trial_new.stress    = cfg.yield_lim;
                trial_new.stiffness = '0;
            end
            else
            begin
                trial_new.stress    = sum[30:0];
                trial_new.stiffness = cfg.modulus;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gap_material_stress_update.sv -----
// top level: beat handshakes, configuration registers, trial and committed state
// depends on gmsu_pkg and gmsu_trial
`timescale 1ns / 1ps
`default_nettype none

// Tension-only gap material point with trial and committed state. Each command beat
// returns exactly one result beat carrying the trial stress and tangent stiffness
// after the operation. A command is first captured in an input register; when the
// result side can take it, the trial datapath (increment, gap and reversal terms,
// modulus product split into two partial products, clamp to 0..yield) updates the
// state and loads the result register. One command is taken every cycle unless the
// result side stalls, set by the update loop through that datapath. Configuration writes
// are applied at once, so issue them only while no command is in flight.
module gap_material_stress_update (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire gmsu_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output gmsu_pkg::res_t     res
);
    import gmsu_pkg::*;

    mat_cfg_t   cfg_reg;
    mat_state_t committed_reg;
    mat_state_t committed_next;
    mat_state_t trial_reg;
    mat_state_t trial_next;
    mat_state_t trial_calc;
    logic       s1_valid_reg;
    cmd_t       s1_cmd_reg;
    logic       res_valid_reg;
    res_t       res_reg;
    logic       advance;
    logic       accept;
    logic signed [32:0] incr_sum;
    logic signed [31:0] step_strain;

    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = s1_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus   <= MODULUS_RESET;
            cfg_reg.yield_lim <= YIELD_RESET;
            cfg_reg.gap       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODULUS: cfg_reg.modulus   <= cfg_data[30:0];
                REG_YIELD:   cfg_reg.yield_lim <= cfg_data[30:0];
                REG_GAP:     cfg_reg.gap       <= $signed(cfg_data);
                default:     ;
            endcase
        end
    end

    // saturating committed strain plus increment
    assign incr_sum = $signed({committed_reg.strain[31], committed_reg.strain})
                    + $signed({s1_cmd_reg.strain_value[31], s1_cmd_reg.strain_value});

    always_comb
    begin
        if (s1_cmd_reg.operation == OP_INCR)
        begin
            if (incr_sum[32] != incr_sum[31])
            begin
                step_strain = incr_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            else
            begin
                step_strain = incr_sum[31:0];
            end
        end
        else
        begin
            step_strain = s1_cmd_reg.strain_value;
        end
    end

    gmsu_trial u_trial (
        .strain    (step_strain),
        .committed (committed_reg),
        .trial     (trial_reg),
        .cfg       (cfg_reg),
        .trial_new (trial_calc)
    );

    always_comb
    begin
        committed_next = committed_reg;
        trial_next     = trial_reg;
        case (s1_cmd_reg.operation)
            OP_TOTAL, OP_INCR:
            begin
                trial_next = trial_calc;
            end
            OP_COMMIT:
            begin
                committed_next = trial_reg;
            end
            OP_REVERT:
            begin
                trial_next = committed_reg;
            end
            OP_CLEAR:
            begin
                committed_next.strain    = '0;
                committed_next.stress    = '0;
                committed_next.stiffness = cfg_reg.modulus;
                committed_next.direction = DIR_NONE;
                committed_next.reversal  = '0;
                trial_next               = committed_next;
            end
            default:
            begin
                trial_next = trial_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg            <= 1'b0;
            res_valid_reg           <= 1'b0;
            committed_reg.strain    <= '0;
            committed_reg.stress    <= '0;
            committed_reg.stiffness <= MODULUS_RESET;
            committed_reg.direction <= DIR_NONE;
            committed_reg.reversal  <= '0;
            trial_reg.strain        <= '0;
            trial_reg.stress        <= '0;
            trial_reg.stiffness     <= MODULUS_RESET;
            trial_reg.direction     <= DIR_NONE;
            trial_reg.reversal      <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                committed_reg <= committed_next;
                trial_reg     <= trial_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
        end
        if (advance)
        begin
            res_reg.stress_out    <= trial_next.stress;
            res_reg.stiffness_out <= trial_next.stiffness;
        end
    end

    a_stall_needs_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg)
        else $error("command stalled with empty input register");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg && res_reg.stress_out == trial_reg.stress
                    && res_reg.stiffness_out == trial_reg.stiffness)
        else $error("result beat does not match trial state");

    a_revert_copies: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_cmd_reg.operation == OP_REVERT |=> trial_reg == committed_reg)
        else $error("revert left trial differing from committed state");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_cmd_reg.operation == OP_CLEAR
        |=> committed_reg.stress == '0 && committed_reg.direction == DIR_NONE
            && trial_reg == committed_reg)
        else $error("clear did not reset the state");

endmodule

`default_nettype wire
